>>> rtl/tpcb_pkg.sv
// Shared constants, codes and types of the two-pass clipped box blur.
// Used by every module of the block but the divider; depends on nothing.
package tpcb_pkg;

  // Default size limits of the frame and the window
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int MAX_HALF_DEF   = 8;

  // Field widths fixed by the interface
  localparam int PIX_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int HALF_FLD_W = 4;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_WINDOW  = 2'd2;

  // Request codes of the input channel
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  // Sequencer states of the top level
  typedef enum logic [2:0] {
    ST_SETUP,
    ST_IDLE,
    ST_FIRST,
    ST_FIRST_WAIT,
    ST_SECOND_WAIT,
    ST_EMIT
  } ctl_state_e;

  // Window walker states
  typedef enum logic [2:0] {
    BX_IDLE,
    BX_CLIP,
    BX_BASE,
    BX_WALK,
    BX_FLUSH,
    BX_START,
    BX_DIV
  } box_state_e;

  // Command from the sequencer to the window walker
  typedef struct packed {
    logic start;
    logic second_pass;
  } box_cmd_t;

  // Answer from the window walker
  typedef struct packed {
    logic             done;
    logic [PIX_W-1:0] avg;
  } box_rsp_t;

endpackage

>>> rtl/tpcb_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on nothing beyond its parameters.
module tpcb_div #(
  parameter int NW = 17,
  parameter int DW = 9
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [NW-1:0] quot_o
);

  localparam int SW = $clog2(NW + 1);

  logic          busy_q;
  logic          done_q;
  logic [SW-1:0] step_q;
  logic [DW:0]   rem_q;
  logic [NW-1:0] quo_q;
  logic [DW-1:0] div_q;
  logic [DW:0]   rem_sh;
  logic          ge;

  // Shift in the next dividend bit and try a subtraction
  always_comb begin
    rem_sh = {rem_q[DW-1:0], quo_q[NW-1]};
    ge     = rem_sh >= {1'b0, div_q};
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= SW'(NW);
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == SW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Advance remainder and quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? (rem_sh - {1'b0, div_q}) : rem_sh;
      quo_q <= {quo_q[NW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

>>> rtl/tpcb_box.sv
// Frame ring memories and the clipped window walker with its divider.
// Depends on tpcb_pkg and tpcb_div.
module tpcb_box #(
  parameter int WW   = 11,
  parameter int HW   = 11,
  parameter int KW   = 4,
  parameter int AW   = 15,
  parameter int CNTW = 9,
  parameter int ACCW = 17
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [WW-1:0]            fw_i,
  input  logic [HW-1:0]            fh_i,
  input  logic [KW-1:0]            k_i,
  input  logic                     in_we_i,
  input  logic [AW-1:0]            in_waddr_i,
  input  logic [tpcb_pkg::PIX_W-1:0] in_wdata_i,
  input  tpcb_pkg::box_cmd_t       cmd_i,
  input  logic [HW-1:0]            row_i,
  input  logic [WW-1:0]            col_i,
  input  logic [AW-1:0]            fp_waddr_i,
  output tpcb_pkg::box_rsp_t       rsp_o
);

  localparam int DEPTH = 2 ** AW;

  tpcb_pkg::box_state_e state_q, state_d;

  logic [tpcb_pkg::PIX_W-1:0] in_mem [DEPTH];
  logic [tpcb_pkg::PIX_W-1:0] fp_mem [DEPTH];
  logic [tpcb_pkg::PIX_W-1:0] in_rd_q;
  logic [tpcb_pkg::PIX_W-1:0] fp_rd_q;

  logic            second_q;
  logic [AW-1:0]   fp_waddr_q;
  logic [HW-1:0]   row_q, r0_q, r1_q, ry_q;
  logic [WW-1:0]   col_q, c0_q, c1_q, cx_q;
  logic [AW-1:0]   row_base_q, addr_q;
  logic [CNTW-1:0] cnt_q;
  logic [ACCW-1:0] acc_q;
  logic            rd_vld_q;

  logic [HW-1:0]   r0_d, r1_d;
  logic [WW-1:0]   c0_d, c1_d;
  logic            div_done;
  logic [ACCW-1:0] quot;
  logic            fp_we;

  // Clip the window to the frame
  always_comb begin
    r0_d = (32'(row_q) > 32'(k_i)) ? HW'(32'(row_q) - 32'(k_i)) : '0;
    r1_d = (32'(row_q) + 32'(k_i) < 32'(fh_i)) ? HW'(32'(row_q) + 32'(k_i))
                                              : HW'(32'(fh_i) - 1);
    c0_d = (32'(col_q) > 32'(k_i)) ? WW'(32'(col_q) - 32'(k_i)) : '0;
    c1_d = (32'(col_q) + 32'(k_i) < 32'(fw_i)) ? WW'(32'(col_q) + 32'(k_i))
                                              : WW'(32'(fw_i) - 1);
  end

  // Next state of the walker
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tpcb_pkg::BX_IDLE:  state_d = tpcb_pkg::BX_IDLE;
      tpcb_pkg::BX_CLIP:  state_d = tpcb_pkg::BX_BASE;
      tpcb_pkg::BX_BASE:  state_d = tpcb_pkg::BX_WALK;
      tpcb_pkg::BX_WALK: begin
        if (cx_q == c1_q && ry_q == r1_q) state_d = tpcb_pkg::BX_FLUSH;
      end
      tpcb_pkg::BX_FLUSH: state_d = tpcb_pkg::BX_START;
      tpcb_pkg::BX_START: state_d = tpcb_pkg::BX_DIV;
      tpcb_pkg::BX_DIV: begin
        if (div_done) state_d = tpcb_pkg::BX_IDLE;
      end
      default: state_d = tpcb_pkg::BX_IDLE;
    endcase
    if (cmd_i.start) state_d = tpcb_pkg::BX_CLIP;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= tpcb_pkg::BX_IDLE;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= (state_q == tpcb_pkg::BX_WALK);
    end
  end

  // Latch the command, set up the window and walk it row by row
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      second_q   <= cmd_i.second_pass;
      fp_waddr_q <= fp_waddr_i;
      row_q      <= row_i;
      col_q      <= col_i;
    end
    unique case (state_q)
      tpcb_pkg::BX_CLIP: begin
        r0_q <= r0_d;
        r1_q <= r1_d;
        c0_q <= c0_d;
        c1_q <= c1_d;
      end
      tpcb_pkg::BX_BASE: begin
        row_base_q <= AW'(32'(r0_q) * 32'(fw_i) + 32'(c0_q));
        addr_q     <= AW'(32'(r0_q) * 32'(fw_i) + 32'(c0_q));
        cnt_q      <= CNTW'((32'(r1_q) - 32'(r0_q) + 1) * (32'(c1_q) - 32'(c0_q) + 1));
        ry_q       <= r0_q;
        cx_q       <= c0_q;
      end
      tpcb_pkg::BX_WALK: begin
        if (cx_q == c1_q) begin
          ry_q       <= ry_q + 1'b1;
          cx_q       <= c0_q;
          row_base_q <= row_base_q + AW'(32'(fw_i));
          addr_q     <= row_base_q + AW'(32'(fw_i));
        end else begin
          cx_q   <= cx_q + 1'b1;
          addr_q <= addr_q + 1'b1;
        end
      end
      default: ;
    endcase
    // Sum the pixels that the registered reads of the cycle before returned
    if (state_q == tpcb_pkg::BX_BASE) begin
      acc_q <= '0;
    end else if (rd_vld_q) begin
      acc_q <= acc_q + ACCW'(second_q ? fp_rd_q : in_rd_q);
    end
  end

  // Input frame ring: written on pixel transfers, read by the first pass
  always_ff @(posedge clk_i) begin
    if (in_we_i) in_mem[in_waddr_i] <= in_wdata_i;
    in_rd_q <= in_mem[addr_q];
  end

  // First-pass ring: written by the first pass, read by the second
  assign fp_we = (state_q == tpcb_pkg::BX_DIV) && div_done && !second_q;

  always_ff @(posedge clk_i) begin
    if (fp_we) fp_mem[fp_waddr_q] <= quot[tpcb_pkg::PIX_W-1:0];
    fp_rd_q <= fp_mem[addr_q];
  end

  tpcb_div #(
    .NW(ACCW),
    .DW(CNTW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == tpcb_pkg::BX_START),
    .dividend_i (acc_q),
    .divisor_i  (cnt_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  assign rsp_o.done = (state_q == tpcb_pkg::BX_DIV) && div_done;
  assign rsp_o.avg  = quot[tpcb_pkg::PIX_W-1:0];

endmodule

>>> rtl/two_pass_clamped_box_blur.sv
// Two-pass clipped box blur of an 8-bit alpha frame: sequencer and ports.
// Depends on tpcb_pkg and tpcb_box.
//
// Pixels go in in raster order; output j leaves once pixel j+2k*width+2k
// is in, drain transfers flush the rest. A pixel or drain that releases
// an output runs the shared window walker once per first-pass pixel that
// comes due (normally one) and once for the second pass; each run reads
// the clipped window, at most (2k+1)^2 pixels, then divides serially.
// Both frame stores are rings with one write port and one registered
// read port, one read per cycle. A write to one of the three registers
// restarts the frame; every write holds input off while it is made, and
// a restart also holds it off through the set-up state.
module two_pass_clamped_box_blur #(
  parameter int MAX_WIDTH  = tpcb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = tpcb_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_HALF   = tpcb_pkg::MAX_HALF_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tpcb_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tpcb_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              req_type_i,
  input  logic [tpcb_pkg::PIX_W-1:0]        alpha_in_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [tpcb_pkg::PIX_W-1:0]        alpha_out_o,
  output logic                              frame_end_o
);

  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int HW   = $clog2(MAX_HEIGHT + 1);
  localparam int KW   = $clog2(MAX_HALF + 1);
  localparam int PW   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int LGW  = $clog2(2 * MAX_HALF * MAX_WIDTH + 2 * MAX_HALF + 1);
  localparam int AW   = $clog2((2 * MAX_HALF + 1) * MAX_WIDTH + 2 * MAX_HALF + 1);
  localparam int SIDE = 2 * MAX_HALF + 1;
  localparam int CNTW = $clog2(SIDE * SIDE + 1);
  localparam int ACCW = $clog2(SIDE * SIDE * 255 + 1);

  tpcb_pkg::ctl_state_e state_q, state_d;

  logic [WW-1:0]  fw_q;
  logic [HW-1:0]  fh_q;
  logic [KW-1:0]  k_q;
  logic [PW-1:0]  n_q;
  logic [LGW-1:0] lag_q;
  logic [PW-1:0]  in_pos_q, out_pos_q, fp_pos_q;
  logic [HW-1:0]  out_y_q, fp_r_q;
  logic [WW-1:0]  out_x_q, fp_c_q;
  logic [tpcb_pkg::PIX_W-1:0] res_q;
  logic           out_valid_q;
  logic [tpcb_pkg::PIX_W-1:0] alpha_q;
  logic           end_q;

  logic           cfg_hit, in_fire, pix_take, emit_go, fp_due, out_load, last;
  logic [31:0]    ry, cx;
  logic [WW-1:0]  v_w;
  logic [HW-1:0]  v_h;
  logic [KW-1:0]  v_k;
  logic [tpcb_pkg::CFG_DATA_W-1:0] v_dim;
  logic [tpcb_pkg::HALF_FLD_W-1:0] v_half;

  tpcb_pkg::box_cmd_t box_cmd;
  tpcb_pkg::box_rsp_t box_rsp;
  logic [HW-1:0]      box_row;
  logic [WW-1:0]      box_col;

  // Clamp configuration values into range
  always_comb begin
    v_dim  = cfg_data_i;
    v_half = cfg_data_i[tpcb_pkg::HALF_FLD_W-1:0];
    if (v_dim == '0) v_w = WW'(1);
    else if (32'(v_dim) > 32'(MAX_WIDTH)) v_w = WW'(MAX_WIDTH);
    else v_w = WW'(v_dim);
    if (v_dim == '0) v_h = HW'(1);
    else if (32'(v_dim) > 32'(MAX_HEIGHT)) v_h = HW'(MAX_HEIGHT);
    else v_h = HW'(v_dim);
    if (v_half == '0) v_k = KW'(1);
    else if (32'(v_half) > 32'(MAX_HALF)) v_k = KW'(MAX_HALF);
    else v_k = KW'(v_half);
  end

  assign cfg_hit = cfg_we_i && (cfg_idx_i == tpcb_pkg::REG_FRAME_WIDTH ||
                                cfg_idx_i == tpcb_pkg::REG_FRAME_HEIGHT ||
                                cfg_idx_i == tpcb_pkg::REG_HALF_WINDOW);

  assign in_ready_o = (state_q == tpcb_pkg::ST_IDLE) && !cfg_we_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign pix_take   = in_fire && req_type_i == tpcb_pkg::REQ_PIXEL && (in_pos_q < n_q);

  // Bottom-right corner of the second-pass window, and whether the
  // first pass still has to reach it
  always_comb begin
    ry = (32'(out_y_q) + 32'(k_q) < 32'(fh_q)) ? 32'(out_y_q) + 32'(k_q) : 32'(fh_q) - 1;
    cx = (32'(out_x_q) + 32'(k_q) < 32'(fw_q)) ? 32'(out_x_q) + 32'(k_q) : 32'(fw_q) - 1;
    fp_due = (32'(fp_r_q) < ry) || (32'(fp_r_q) == ry && 32'(fp_c_q) <= cx);
  end

  assign last = (32'(out_pos_q) + 1 == 32'(n_q));

  // Sequencer: next state and walker commands
  always_comb begin
    state_d  = state_q;
    emit_go  = 1'b0;
    out_load = 1'b0;
    box_cmd  = '0;
    box_row  = out_y_q;
    box_col  = out_x_q;
    unique case (state_q)
      tpcb_pkg::ST_SETUP: state_d = tpcb_pkg::ST_IDLE;
      tpcb_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (req_type_i == tpcb_pkg::REQ_PIXEL) begin
            emit_go = pix_take && (out_pos_q < n_q) &&
                      (32'(out_pos_q) + 32'(lag_q) <= 32'(in_pos_q));
          end else begin
            emit_go = (in_pos_q == n_q) && (out_pos_q < n_q);
          end
          if (emit_go) state_d = tpcb_pkg::ST_FIRST;
        end
      end
      tpcb_pkg::ST_FIRST: begin
        box_cmd.start = 1'b1;
        if (fp_due) begin
          box_row = fp_r_q;
          box_col = fp_c_q;
          state_d = tpcb_pkg::ST_FIRST_WAIT;
        end else begin
          box_cmd.second_pass = 1'b1;
          state_d = tpcb_pkg::ST_SECOND_WAIT;
        end
      end
      tpcb_pkg::ST_FIRST_WAIT: begin
        if (box_rsp.done) state_d = tpcb_pkg::ST_FIRST;
      end
      tpcb_pkg::ST_SECOND_WAIT: begin
        if (box_rsp.done) state_d = tpcb_pkg::ST_EMIT;
      end
      tpcb_pkg::ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = tpcb_pkg::ST_IDLE;
        end
      end
      default: state_d = tpcb_pkg::ST_IDLE;
    endcase
    if (cfg_hit) state_d = tpcb_pkg::ST_SETUP;
  end

  // Hold control state, positions and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tpcb_pkg::ST_SETUP;
      fw_q        <= WW'(1);
      fh_q        <= HW'(1);
      k_q         <= KW'(1);
      n_q         <= PW'(1);
      lag_q       <= LGW'(4);
      in_pos_q    <= '0;
      out_pos_q   <= '0;
      fp_pos_q    <= '0;
      out_y_q     <= '0;
      out_x_q     <= '0;
      fp_r_q      <= '0;
      fp_c_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (out_load) out_valid_q <= 1'b1;
      // Derive frame size and latency after a register write
      if (state_q == tpcb_pkg::ST_SETUP) begin
        n_q   <= PW'(32'(fw_q) * 32'(fh_q));
        lag_q <= LGW'((32'(k_q) * 32'(fw_q) + 32'(k_q)) << 1);
      end
      if (pix_take) in_pos_q <= in_pos_q + 1'b1;
      // Step the first pass one pixel
      if (state_q == tpcb_pkg::ST_FIRST_WAIT && box_rsp.done) begin
        fp_pos_q <= fp_pos_q + 1'b1;
        if (32'(fp_c_q) + 1 == 32'(fw_q)) begin
          fp_c_q <= '0;
          fp_r_q <= fp_r_q + 1'b1;
        end else begin
          fp_c_q <= fp_c_q + 1'b1;
        end
      end
      // Step the output position; drop the frame after its last pixel
      if (out_load) begin
        out_pos_q <= out_pos_q + 1'b1;
        if (32'(out_x_q) + 1 == 32'(fw_q)) begin
          out_x_q <= '0;
          out_y_q <= out_y_q + 1'b1;
        end else begin
          out_x_q <= out_x_q + 1'b1;
        end
        if (last) begin
          in_pos_q  <= '0;
          out_pos_q <= '0;
          fp_pos_q  <= '0;
          out_y_q   <= '0;
          out_x_q   <= '0;
          fp_r_q    <= '0;
          fp_c_q    <= '0;
        end
      end
      if (cfg_hit) begin
        unique case (cfg_idx_i)
          tpcb_pkg::REG_FRAME_WIDTH:  fw_q <= v_w;
          tpcb_pkg::REG_FRAME_HEIGHT: fh_q <= v_h;
          default:                    k_q  <= v_k;
        endcase
        in_pos_q  <= '0;
        out_pos_q <= '0;
        fp_pos_q  <= '0;
        out_y_q   <= '0;
        out_x_q   <= '0;
        fp_r_q    <= '0;
        fp_c_q    <= '0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (state_q == tpcb_pkg::ST_SECOND_WAIT && box_rsp.done) res_q <= box_rsp.avg;
    if (out_load) begin
      alpha_q <= res_q;
      end_q   <= last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign alpha_out_o = alpha_q;
  assign frame_end_o = end_q;

  tpcb_box #(
    .WW  (WW),
    .HW  (HW),
    .KW  (KW),
    .AW  (AW),
    .CNTW(CNTW),
    .ACCW(ACCW)
  ) u_box (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fw_i       (fw_q),
    .fh_i       (fh_q),
    .k_i        (k_q),
    .in_we_i    (pix_take),
    .in_waddr_i (AW'(in_pos_q)),
    .in_wdata_i (alpha_in_i),
    .cmd_i      (box_cmd),
    .row_i      (box_row),
    .col_i      (box_col),
    .fp_waddr_i (AW'(fp_pos_q)),
    .rsp_o      (box_rsp)
  );

endmodule

>>> rtl/tpcb_checker.sv
// Port-level checks of the two-pass clipped box blur, bound to the top.
// Depends on tpcb_pkg and the top level's ports.
module tpcb_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           cfg_we_i,
  input logic [tpcb_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [7:0]                     alpha_out_o,
  input logic                           frame_end_o
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(alpha_out_o) &&
    $stable(frame_end_o))
    else $error("result changed while stalled");

  // No input transfer alongside a register write
  a_cfg_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |-> !in_ready_o)
    else $error("input ready during register write");

  // A write to a listed register holds input off for the set-up cycle
  a_cfg_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && (cfg_idx_i <= tpcb_pkg::REG_HALF_WINDOW) |=> !in_ready_o)
    else $error("input ready right after register write");

endmodule

bind two_pass_clamped_box_blur tpcb_checker u_checker (.*);
